// ----- design/tcsw_pkg.sv -----
// Shared types, constants and address/field helpers for the tag cache.
package tcsw_pkg;

  localparam int unsigned SETS        = 256;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned WORDS       = 8;
  localparam int unsigned SET_W       = 8;
  localparam int unsigned WAY_W       = 2;
  localparam int unsigned WORD_W      = 3;
  localparam int unsigned TAG_W       = 21;
  localparam int unsigned DATA_ADDR_W = SET_W + WAY_W + WORD_W;
  localparam int unsigned DATA_DEPTH  = SETS * WAYS * WORDS;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_ALLOC  = 2'd2;
  localparam logic [1:0] OP_REFILL = 2'd3;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_WB     = 2'd1;
  localparam logic [1:0] KIND_REFILL = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [63:0] write_data;
  } item_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_address;
    logic [63:0] result_data;
    logic        was_hit;
    logic        last;
  } item_out_t;

  typedef struct packed {
    logic      valid;
    item_out_t item;
  } emit_t;

  typedef struct packed {
    logic       compress_zero_lines;
    logic [2:0] tag_size_log2;
    logic [2:0] granule_log2;
  } cfg_t;

  typedef struct packed {
    item_in_t         item;
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } work_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } way_meta_t;

  typedef struct packed {
    way_meta_t [WAYS-1:0] ways;
    logic [2:0]           plru;
  } meta_row_t;

  localparam int unsigned META_W = $bits(meta_row_t);

  function automatic logic [2:0] eff_tsl(cfg_t c);
    return (c.tag_size_log2 > 3'd6) ? 3'd6 : c.tag_size_log2;
  endfunction

  function automatic logic [2:0] eff_g(cfg_t c);
    logic [2:0] g;
    g = c.granule_log2;
    if (g < 3'd3) g = 3'd3;
    if (g > 3'd6) g = 3'd6;
    return g;
  endfunction

  function automatic logic [3:0] line_shift(cfg_t c);
    return 4'd6 + {1'b0, eff_g(c)} - {1'b0, eff_tsl(c)};
  endfunction

  function automatic logic [3:0] word_shift(cfg_t c);
    return 4'd3 + {1'b0, eff_g(c)} - {1'b0, eff_tsl(c)};
  endfunction

  function automatic logic [1:0] gran_shift(cfg_t c);
    logic [2:0] s;
    s = eff_g(c) - 3'd3;
    return s[1:0];
  endfunction

  function automatic logic [SET_W-1:0] set_of(logic [31:0] addr, cfg_t c);
    logic [31:0] s;
    s = addr >> line_shift(c);
    return s[SET_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(logic [31:0] addr, cfg_t c);
    logic [31:0] s;
    s = addr >> ({1'b0, line_shift(c)} + 5'd8);
    return s[TAG_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] word_of(logic [31:0] addr, cfg_t c);
    logic [31:0] s;
    s = addr >> word_shift(c);
    return s[WORD_W-1:0];
  endfunction

  function automatic logic [5:0] field_pos(logic [31:0] addr, cfg_t c);
    logic [31:0] s;
    logic [6:0]  m;
    logic [5:0]  fi;
    s  = addr >> gran_shift(c);
    m  = (7'd1 << (3'd6 - eff_tsl(c))) - 7'd1;
    fi = s[5:0] & m[5:0];
    return fi << eff_tsl(c);
  endfunction

  function automatic logic [63:0] field_mask(cfg_t c);
    logic [6:0] w;
    w = 7'd1 << eff_tsl(c);
    return (eff_tsl(c) == 3'd6) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] read_field(logic [63:0] word, logic [31:0] addr, cfg_t c);
    return (eff_tsl(c) == 3'd6) ? word : ((word >> field_pos(addr, c)) & field_mask(c));
  endfunction

  function automatic logic [63:0] merge_field(logic [63:0] word, logic [63:0] data,
                                              logic [31:0] addr, cfg_t c);
    logic [63:0] m;
    logic [5:0]  p;
    m = field_mask(c);
    p = field_pos(addr, c);
    return (eff_tsl(c) == 3'd6) ? data : ((word & ~(m << p)) | ((data & m) << p));
  endfunction

  function automatic logic [WAY_W-1:0] plru_victim(logic [2:0] b);
    return b[0] ? (b[2] ? 2'd3 : 2'd2) : (b[1] ? 2'd1 : 2'd0);
  endfunction

  function automatic logic [2:0] plru_touch(logic [2:0] b, logic [WAY_W-1:0] way);
    logic [2:0] r;
    r = b;
    if (way[1]) begin
      r[0] = 1'b0;
      r[2] = ~way[0];
    end else begin
      r[0] = 1'b1;
      r[1] = ~way[0];
    end
    return r;
  endfunction

  function automatic logic [31:0] wb_addr(logic [TAG_W-1:0] tag, logic [SET_W-1:0] set,
                                          logic [WORD_W-1:0] idx, cfg_t c);
    logic [39:0] base;
    logic [31:0] off;
    base = {11'd0, tag, set} << line_shift(c);
    off  = {29'd0, idx} << word_shift(c);
    return base[31:0] + off;
  endfunction

  function automatic logic [31:0] line_base(logic [31:0] addr, cfg_t c);
    return addr & (32'hFFFF_FFFF << line_shift(c));
  endfunction

endpackage

// ----- design/tag_cache_set_assoc_writeback_unit.sv -----
// Tag cache top level: 256 sets x 4 ways, 64-byte lines of eight 64-bit words,
// write-back and write-allocate with tree pseudo-LRU. After reset the tag store
// is swept clear set by set, during which full stays high. Items queue in a
// two-entry front queue and are worked one at a time by the back end, which
// owns the tag and data memories, each with one write and one read port. A
// refill word is written as it arrives; the last one then runs the pending access.
// A miss on a dirty victim first reads the line and then streams it out, unless
// zero-line compression is on and the line is all zeros; an allocate miss zero fills.
// Results leave through a two-entry queue; a full result queue holds the back end.
module tag_cache_set_assoc_writeback_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tcsw_pkg::item_in_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output tcsw_pkg::item_out_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [1:0] REG_COMPRESS = 2'd0;
  localparam logic [1:0] REG_TAG_SIZE = 2'd1;
  localparam logic [1:0] REG_GRANULE  = 2'd2;

  tcsw_pkg::cfg_t  cfg_q;
  logic            busy, q_valid, q_pop, out_ready;
  tcsw_pkg::work_t q_work;
  tcsw_pkg::emit_t emit;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.compress_zero_lines <= 1'b0;
      cfg_q.tag_size_log2       <= 3'd6;
      cfg_q.granule_log2        <= 3'd6;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_COMPRESS: cfg_q.compress_zero_lines <= pwdata[0];
        REG_TAG_SIZE: cfg_q.tag_size_log2       <= pwdata[2:0];
        REG_GRANULE:  cfg_q.granule_log2        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COMPRESS: prdata = {31'd0, cfg_q.compress_zero_lines};
      REG_TAG_SIZE: prdata = {29'd0, cfg_q.tag_size_log2};
      REG_GRANULE:  prdata = {29'd0, cfg_q.granule_log2};
      default:      prdata = 32'd0;
    endcase
  end

  tcsw_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .busy_i  (busy),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .work_o  (q_work)
  );

  tcsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (q_valid),
    .work_i      (q_work),
    .pop_o       (q_pop),
    .busy_o      (busy),
    .out_ready_i (out_ready),
    .emit_o      (emit)
  );

  tcsw_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .ready_o (out_ready),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (out_item_o)
  );

  // No item may enter while the tag store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> full)
    else $error("item accepted during tag store clear");

  // The back end only produces a result when the result queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit.valid |-> out_ready)
    else $error("result produced into a full result queue");

  // A waiting result is not lost without being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (!empty && !pop) |=> !empty)
    else $error("waiting result vanished");

  // The back end never dequeues a work item that is not there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("front queue popped while empty");

endmodule

// ----- design/tcsw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcsw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/tcsw_front.sv -----
// Front end: accepts items, decodes set and tag, holds them in a two-entry queue.
module tcsw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  tcsw_pkg::item_in_t item_i,
  input  tcsw_pkg::cfg_t     cfg_i,
  input  logic               busy_i,
  input  logic               pop_i,
  output logic               valid_o,
  output tcsw_pkg::work_t    work_o
);

  tcsw_pkg::work_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign full_o  = busy_i | (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign work_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q].item <= item_i;
      mem_q[wr_q].set  <= tcsw_pkg::set_of(item_i.address, cfg_i);
      mem_q[wr_q].tag  <= tcsw_pkg::tag_of(item_i.address, cfg_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- design/tcsw_back.sv -----
// Back end: tag lookup, write-back, refill tracking and field access.
module tcsw_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcsw_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  input  tcsw_pkg::work_t work_i,
  output logic            pop_o,
  output logic            busy_o,
  input  logic            out_ready_i,
  output tcsw_pkg::emit_t emit_o
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_META   = 10'b00_0000_0100,
    S_ROW    = 10'b00_0000_1000,
    S_DECIDE = 10'b00_0001_0000,
    S_ACCESS = 10'b00_0010_0000,
    S_WBRD   = 10'b00_0100_0000,
    S_WBOUT  = 10'b00_1000_0000,
    S_ZERO   = 10'b01_0000_0000,
    S_MISS   = 10'b10_0000_0000
  } state_e;

  state_e                              state_q, state_d;
  logic [tcsw_pkg::SET_W-1:0]          clr_q, clr_d;
  tcsw_pkg::work_t                     cur_q, cur_d, pend_q, pend_d;
  logic                                fill_mode_q, fill_mode_d;
  logic                                pend_valid_q, pend_valid_d;
  logic [tcsw_pkg::WAY_W-1:0]          pend_way_q, pend_way_d;
  logic [tcsw_pkg::WORD_W-1:0]         fill_cnt_q, fill_cnt_d;
  tcsw_pkg::meta_row_t                 row_q, row_d;
  logic [tcsw_pkg::WAY_W-1:0]          way_q, way_d;
  logic                                hit_q, hit_d;
  logic [3:0]                          cnt_q, cnt_d;
  logic [63:0]                         wb_buf_q [8];
  logic [63:0]                         wb_buf_d [8];
  logic                                nz_q, nz_d;

  logic                                m_we, m_re;
  logic [tcsw_pkg::SET_W-1:0]          m_waddr, m_raddr;
  logic [tcsw_pkg::META_W-1:0]         m_wdata, m_rdata;
  logic                                d_we, d_re;
  logic [tcsw_pkg::DATA_ADDR_W-1:0]    d_waddr, d_raddr;
  logic [63:0]                         d_wdata, d_rdata;

  logic                                hit;
  logic [tcsw_pkg::WAY_W-1:0]          hway, victim;
  logic [tcsw_pkg::WORD_W-1:0]         widx;
  state_e                              after_miss;
  tcsw_pkg::meta_row_t                 row_n;
  logic [63:0]                         word_n;

  tcsw_ram #(.Width(tcsw_pkg::META_W), .Depth(tcsw_pkg::SETS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  tcsw_ram #(.Width(64), .Depth(tcsw_pkg::DATA_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  assign busy_o = (state_q == S_CLEAR);
  assign widx   = tcsw_pkg::word_of(cur_q.item.address, cfg_i);
  assign victim = tcsw_pkg::plru_victim(row_q.plru);
  assign after_miss = (cur_q.item.operation == tcsw_pkg::OP_ALLOC) ? S_ZERO : S_MISS;

  // The lowest-numbered matching way wins.
  always_comb begin
    hit  = 1'b0;
    hway = '0;
    for (int i = tcsw_pkg::WAYS - 1; i >= 0; i--) begin
      if (row_q.ways[i].valid && row_q.ways[i].tag == cur_q.tag) begin
        hit  = 1'b1;
        hway = tcsw_pkg::WAY_W'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    pend_d       = pend_q;
    fill_mode_d  = fill_mode_q;
    pend_valid_d = pend_valid_q;
    pend_way_d   = pend_way_q;
    fill_cnt_d   = fill_cnt_q;
    row_d        = row_q;
    way_d        = way_q;
    hit_d        = hit_q;
    cnt_d        = cnt_q;
    wb_buf_d     = wb_buf_q;
    nz_d         = nz_q;
    pop_o        = 1'b0;
    m_we         = 1'b0;
    m_waddr      = cur_q.set;
    m_wdata      = '0;
    m_re         = 1'b0;
    m_raddr      = cur_q.set;
    d_we         = 1'b0;
    d_waddr      = {cur_q.set, way_q, widx};
    d_wdata      = '0;
    d_re         = 1'b0;
    d_raddr      = {cur_q.set, way_q, widx};
    emit_o       = '0;
    row_n        = row_q;
    word_n       = d_rdata;

    case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        clr_d   = clr_q + tcsw_pkg::SET_W'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          if (pend_valid_q) begin
            if (work_i.item.operation == tcsw_pkg::OP_REFILL) begin
              d_we       = 1'b1;
              d_waddr    = {pend_q.set, pend_way_q, fill_cnt_q};
              d_wdata    = work_i.item.write_data;
              fill_cnt_d = fill_cnt_q + tcsw_pkg::WORD_W'(1);
              if (fill_cnt_q == '1) begin
                cur_d        = pend_q;
                way_d        = pend_way_q;
                fill_mode_d  = 1'b1;
                pend_valid_d = 1'b0;
                state_d      = S_META;
              end
            end
          end else if (work_i.item.operation != tcsw_pkg::OP_REFILL) begin
            cur_d       = work_i;
            fill_mode_d = 1'b0;
            state_d     = S_META;
          end
        end
      end

      S_META: begin
        m_re    = 1'b1;
        state_d = S_ROW;
      end

      S_ROW: begin
        row_d   = tcsw_pkg::meta_row_t'(m_rdata);
        state_d = S_DECIDE;
      end

      S_DECIDE: begin
        if (fill_mode_q) begin
          d_re    = 1'b1;
          hit_d   = 1'b0;
          state_d = S_ACCESS;
        end else if (hit) begin
          if (cur_q.item.operation == tcsw_pkg::OP_ALLOC) begin
            if (out_ready_i) begin
              row_n.plru = tcsw_pkg::plru_touch(row_q.plru, hway);
              m_we       = 1'b1;
              m_wdata    = row_n;
              emit_o.valid              = 1'b1;
              emit_o.item.result_kind   = tcsw_pkg::KIND_DONE;
              emit_o.item.was_hit       = 1'b1;
              emit_o.item.last          = 1'b1;
              state_d    = S_IDLE;
            end
          end else begin
            way_d   = hway;
            hit_d   = 1'b1;
            d_re    = 1'b1;
            d_raddr = {cur_q.set, hway, widx};
            state_d = S_ACCESS;
          end
        end else begin
          way_d = victim;
          cnt_d = '0;
          nz_d  = 1'b0;
          if (row_q.ways[victim].valid && row_q.ways[victim].dirty) state_d = S_WBRD;
          else state_d = after_miss;
        end
      end

      S_ACCESS: begin
        if (out_ready_i) begin
          if (fill_mode_q) begin
            row_n.ways[way_q].valid = 1'b1;
            row_n.ways[way_q].tag   = cur_q.tag;
            row_n.ways[way_q].dirty = 1'b0;
          end
          if (cur_q.item.operation == tcsw_pkg::OP_WRITE) begin
            word_n  = tcsw_pkg::merge_field(d_rdata, cur_q.item.write_data,
                                            cur_q.item.address, cfg_i);
            d_we    = 1'b1;
            d_wdata = word_n;
            row_n.ways[way_q].dirty = 1'b1;
          end
          row_n.plru = tcsw_pkg::plru_touch(row_q.plru, way_q);
          m_we       = 1'b1;
          m_wdata    = row_n;
          emit_o.valid            = 1'b1;
          emit_o.item.result_kind = tcsw_pkg::KIND_DONE;
          emit_o.item.result_data = (cur_q.item.operation == tcsw_pkg::OP_READ) ?
              tcsw_pkg::read_field(d_rdata, cur_q.item.address, cfg_i) : 64'd0;
          emit_o.item.was_hit     = hit_q;
          emit_o.item.last        = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Read the victim line into the shift buffer, one word behind the read.
      S_WBRD: begin
        d_re    = ~cnt_q[3];
        d_raddr = {cur_q.set, way_q, cnt_q[2:0]};
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q != 4'd0) begin
          for (int i = 0; i < 7; i++) wb_buf_d[i] = wb_buf_q[i+1];
          wb_buf_d[7] = d_rdata;
          nz_d = nz_q | (d_rdata != 64'd0);
        end
        if (cnt_q == 4'd8) begin
          cnt_d = '0;
          if (cfg_i.compress_zero_lines && !nz_d) state_d = after_miss;
          else state_d = S_WBOUT;
        end
      end

      S_WBOUT: begin
        if (out_ready_i) begin
          emit_o.valid               = 1'b1;
          emit_o.item.result_kind    = tcsw_pkg::KIND_WB;
          emit_o.item.result_address = tcsw_pkg::wb_addr(row_q.ways[way_q].tag, cur_q.set,
                                                         cnt_q[2:0], cfg_i);
          emit_o.item.result_data    = wb_buf_q[0];
          for (int i = 0; i < 7; i++) wb_buf_d[i] = wb_buf_q[i+1];
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd7) begin
            cnt_d   = '0;
            state_d = after_miss;
          end
        end
      end

      S_ZERO: begin
        d_we    = 1'b1;
        d_waddr = {cur_q.set, way_q, cnt_q[2:0]};
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          cnt_d   = '0;
          state_d = S_MISS;
        end
      end

      S_MISS: begin
        if (out_ready_i) begin
          emit_o.valid     = 1'b1;
          emit_o.item.last = 1'b1;
          if (cur_q.item.operation == tcsw_pkg::OP_ALLOC) begin
            row_n.ways[way_q].valid = 1'b1;
            row_n.ways[way_q].dirty = 1'b0;
            row_n.ways[way_q].tag   = cur_q.tag;
            row_n.plru = tcsw_pkg::plru_touch(row_q.plru, way_q);
            emit_o.item.result_kind = tcsw_pkg::KIND_DONE;
          end else begin
            row_n.ways[way_q].valid = 1'b0;
            row_n.ways[way_q].dirty = 1'b0;
            pend_d       = cur_q;
            pend_way_d   = way_q;
            pend_valid_d = 1'b1;
            fill_cnt_d   = '0;
            emit_o.item.result_kind    = tcsw_pkg::KIND_REFILL;
            emit_o.item.result_address = tcsw_pkg::line_base(cur_q.item.address, cfg_i);
          end
          m_we    = 1'b1;
          m_wdata = row_n;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    pend_q   <= pend_d;
    row_q    <= row_d;
    way_q    <= way_d;
    hit_q    <= hit_d;
    wb_buf_q <= wb_buf_d;
    nz_q     <= nz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      fill_mode_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_way_q   <= '0;
      fill_cnt_q   <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      fill_mode_q  <= fill_mode_d;
      pend_valid_q <= pend_valid_d;
      pend_way_q   <= pend_way_d;
      fill_cnt_q   <= fill_cnt_d;
      cnt_q        <= cnt_d;
    end
  end

endmodule

// ----- design/tcsw_outq.sv -----
// Two-entry result queue between the back end and the result ports.
module tcsw_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcsw_pkg::emit_t     emit_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tcsw_pkg::item_out_t item_o
);

  tcsw_pkg::item_out_t mem_q [2];
  logic                wr_q, rd_q;
  logic [1:0]          cnt_q;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];
  assign do_push = emit_i.valid & ready_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= emit_i.item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
